// ----- rtl/dmad_pkg.sv -----
// Shared types, operation codes and pipeline constants of the digit multiply-add-divide unit.
`default_nettype none

package dmad_pkg;

	// Operation codes.
	localparam logic [2:0] OP_MUL_SPLIT     = 3'd0;
	localparam logic [2:0] OP_MULADD_SPLIT  = 3'd1;
	localparam logic [2:0] OP_MUL_DIVMOD    = 3'd2;
	localparam logic [2:0] OP_MULADD_DIVMOD = 3'd3;
	localparam logic [2:0] OP_MULADD_MOD    = 3'd4;
	localparam logic [2:0] OP_SHIFT_DIVMOD  = 3'd5;
	localparam logic [2:0] OP_DIVIDE        = 3'd6;

	// The divider retires 64 dividend bits, STEPS_PER_STAGE of them in each stage.
	localparam int DIVIDEND_BITS   = 64;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = DIVIDEND_BITS / STEPS_PER_STAGE;

	// Clock edges from the accepting edge to the edge at which done is first sampled high.
	localparam int PIPE_LATENCY = DIV_STAGES + 3;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] first_operand;
		logic [31:0] second_operand;
		logic [31:0] addend;
		logic [31:0] divisor;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] low_or_remainder;
		logic [31:0] high_or_quotient;
		logic        divide_error;
	} out_beat_t;

	// How the divider output is turned into the result beat.
	typedef struct packed {
		logic keep_q;
		logic keep_r;
		logic err;
	} out_ctl_t;

	// Data that moves through one divider stage.
	typedef struct packed {
		logic [31:0] rem;
		logic [63:0] tq;
		logic [31:0] dvs;
		out_ctl_t    ctl;
	} div_stage_t;

	// One restoring division step: bring in the next dividend bit, subtract when it fits,
	// and shift the quotient bit into the bottom of the dividend word.
	function automatic div_stage_t div_step(input div_stage_t cur);
		logic [32:0] sh;
		logic [32:0] df;
		div_stage_t  nx;
		nx = cur;
		sh = {cur.rem, cur.tq[63]};
		df = sh - {1'b0, cur.dvs};
		if (!df[32]) begin
			nx.rem = df[31:0];
			nx.tq  = {cur.tq[62:0], 1'b1};
		end else begin
			nx.rem = sh[31:0];
			nx.tq  = {cur.tq[62:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/digit_mul_add_divmod_unit.sv -----
// Top level of the digit multiply-add-divide unit: multiplier, operand select and pipelined divider.
// A beat passes the stage 1 registers, the stage 2 divider entry, the divider stages and the output register to done.
// Throughput: one beat per clock cycle; busy is never raised and the result cannot be held off.
// The 64-bit restoring divider retires four quotient bits per stage over sixteen stages.
// Split operations divide by 2^DIGIT_BITS, which yields the digit split exactly.
// Reset clears all valid bits at once; data registers are not reset.
`default_nettype none

module digit_mul_add_divmod_unit
	import dmad_pkg::*;
#(
	parameter int DIGIT_BITS = 27
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	output logic      busy,
	input  in_beat_t  item,
	output logic      done,
	output out_beat_t res
);

	localparam logic [31:0] SPLIT_DIVISOR = 32'd1 << DIGIT_BITS;

	// Stage 1 registers: product and the operands that follow it.
	logic        vld_s1;
	logic [2:0]  op_s1;
	logic [63:0] prod_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic [31:0] c_s1;
	logic [31:0] d_s1;

	// Stage 2 registers: divider entry.
	logic       vld_s2;
	div_stage_t entry_s2;

	// Divider stages, one register set per stage.
	logic [DIV_STAGES-1:0] div_vld_s;
	div_stage_t            div_s  [DIV_STAGES];
	div_stage_t            stg_in [DIV_STAGES];
	div_stage_t            stg_nx [DIV_STAGES];

	// Output register.
	logic      done_q;
	out_beat_t res_q;

	// Stage 2 combinational values.
	logic [63:0] t_c;
	logic [31:0] dvs_c;
	out_ctl_t    ctl_c;
	logic        dzero_c;

	// The pipeline never stalls, so a beat is taken every cycle.
	assign busy = 1'b0;

	// Stage 1: valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	// Stage 1: the 32 by 32 product and the operands.
	always_ff @(posedge clk) begin
		op_s1   <= item.op;
		prod_s1 <= {32'd0, item.first_operand} * {32'd0, item.second_operand};
		a_s1    <= item.first_operand;
		b_s1    <= item.second_operand;
		c_s1    <= item.addend;
		d_s1    <= item.divisor;
	end

	// Stage 2: form the dividend, divisor and output control for each operation.
	always_comb begin
		dzero_c = (d_s1 == 32'd0);
		t_c     = 64'd0;
		dvs_c   = d_s1;
		ctl_c   = '{keep_q: 1'b0, keep_r: 1'b0, err: 1'b0};
		case (op_s1)
			OP_MUL_SPLIT: begin
				t_c   = prod_s1;
				dvs_c = SPLIT_DIVISOR;
				ctl_c = '{keep_q: 1'b1, keep_r: 1'b1, err: 1'b0};
			end
			OP_MULADD_SPLIT: begin
				t_c   = prod_s1 + {32'd0, c_s1};
				dvs_c = SPLIT_DIVISOR;
				ctl_c = '{keep_q: 1'b1, keep_r: 1'b1, err: 1'b0};
			end
			OP_MUL_DIVMOD: begin
				t_c   = prod_s1;
				ctl_c = '{keep_q: !dzero_c, keep_r: !dzero_c, err: dzero_c};
			end
			OP_MULADD_DIVMOD: begin
				t_c   = prod_s1 + {32'd0, c_s1};
				ctl_c = '{keep_q: !dzero_c, keep_r: !dzero_c, err: dzero_c};
			end
			OP_MULADD_MOD: begin
				t_c   = prod_s1 + {32'd0, c_s1};
				ctl_c = '{keep_q: 1'b0, keep_r: !dzero_c, err: dzero_c};
			end
			OP_SHIFT_DIVMOD: begin
				t_c   = ({32'd0, a_s1} << DIGIT_BITS) + {32'd0, b_s1};
				ctl_c = '{keep_q: !dzero_c, keep_r: !dzero_c, err: dzero_c};
			end
			OP_DIVIDE: begin
				t_c   = {32'd0, a_s1};
				ctl_c = '{keep_q: !dzero_c, keep_r: !dzero_c, err: dzero_c};
			end
			default: begin
				t_c   = 64'd0;
				ctl_c = '{keep_q: 1'b0, keep_r: 1'b0, err: 1'b0};
			end
		endcase
	end

	// Stage 2: valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: divider entry with a cleared partial remainder.
	always_ff @(posedge clk) begin
		entry_s2.rem <= 32'd0;
		entry_s2.tq  <= t_c;
		entry_s2.dvs <= dvs_c;
		entry_s2.ctl <= ctl_c;
	end

	// Divider stages: each one retires STEPS_PER_STAGE dividend bits.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		if (g == 0) begin : g_first
			assign stg_in[g] = entry_s2;

			// The first stage takes the valid bit of the divider entry.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_s[g] <= 1'b0;
				end else begin
					div_vld_s[g] <= vld_s2;
				end
			end
		end else begin : g_next
			assign stg_in[g] = div_s[g-1];

			// Later stages take the valid bit of the stage before.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_s[g] <= 1'b0;
				end else begin
					div_vld_s[g] <= div_vld_s[g-1];
				end
			end
		end

		always_comb begin
			div_stage_t w;
			w = stg_in[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				w = div_step(w);
			end
			stg_nx[g] = w;
		end

		always_ff @(posedge clk) begin
			div_s[g] <= stg_nx[g];
		end
	end

	// Output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld_s[DIV_STAGES-1];
		end
	end

	// Output beat: the quotient sits in the low half of the shifted dividend word.
	always_ff @(posedge clk) begin
		res_q.low_or_remainder <= div_s[DIV_STAGES-1].ctl.keep_r ?
			div_s[DIV_STAGES-1].rem : 32'd0;
		res_q.high_or_quotient <= div_s[DIV_STAGES-1].ctl.keep_q ?
			div_s[DIV_STAGES-1].tq[31:0] : 32'd0;
		res_q.divide_error     <= div_s[DIV_STAGES-1].ctl.err;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ----- rtl/dmad_checker.sv -----
// Port-level checker of the digit multiply-add-divide unit and its bind to the top level.
`default_nettype none

module dmad_checker
	import dmad_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input in_beat_t  item,
	input wire       done,
	input out_beat_t res
);

	// Every accepted beat yields its result after the fixed pipeline latency.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("accepted beat produced no result at the pipeline latency");

	// A result strobe is always caused by a beat accepted one latency earlier.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result strobe without a matching accepted beat");

	// A reported divide error comes with both result words cleared.
	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.divide_error) |->
		(res.low_or_remainder == 32'd0 && res.high_or_quotient == 32'd0))
		else $error("divide error with nonzero result words");

	// The remainder-only operation never reports a quotient.
	a_mod_no_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && item.op == OP_MULADD_MOD, PIPE_LATENCY)) |->
		(res.high_or_quotient == 32'd0))
		else $error("remainder-only operation returned a quotient");

endmodule

bind digit_mul_add_divmod_unit dmad_checker u_dmad_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.res    (res)
);

`default_nettype wire
